// File: rtl/double_ended_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Double-ended queue core - assertion macros
// Shared concurrent assertion helpers; bodies are empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DEQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DEQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Field widths, operation codes, default depth and the compare result type.
// ----------------------------------------------------------------------------
package deq_pkg;

  // field widths
  localparam int unsigned OP_W  = 3;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned POS_W = 4;
  localparam int unsigned OCC_W = 5;

  // default ring depth
  localparam int unsigned DEPTH_DEF = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

  // compare unit result
  typedef struct packed {
    logic less;
    logic equal;
  } cmp_res_t;

endpackage

// File: rtl/deq_in_if.sv
// ----------------------------------------------------------------------------
// Deque input channel
// Valid/ready channel carrying one operation and its key.
// ----------------------------------------------------------------------------
interface deq_in_if;
  import deq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);

endinterface

// File: rtl/deq_out_if.sv
// ----------------------------------------------------------------------------
// Deque result channel
// Valid/ready channel carrying one result per operation.
// ----------------------------------------------------------------------------
interface deq_out_if;
  import deq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    ok;
  logic signed [KEY_W-1:0] key_out;
  logic [POS_W-1:0]        position;
  logic [OCC_W-1:0]        occupancy;

  modport source (output valid, output ok, output key_out, output position,
                  output occupancy, input ready);
  modport sink   (input valid, input ok, input key_out, input position,
                  input occupancy, output ready);

endinterface

// File: rtl/deq_ring_mem.sv
// ----------------------------------------------------------------------------
// Deque ring store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_ring_mem #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [AW-1:0]                    waddr_i,
  input  logic signed [deq_pkg::KEY_W-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [AW-1:0]                    raddr_i,
  output logic signed [deq_pkg::KEY_W-1:0] rdata_o
);
  import deq_pkg::*;

  logic signed [KEY_W-1:0] mem [DEPTH];
  logic signed [KEY_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data valid the cycle after the request
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/deq_walk_cmp.sv
// ----------------------------------------------------------------------------
// Deque key compare unit
// Signed less-than and equality of a stored key against the probe key.
// ----------------------------------------------------------------------------
module deq_walk_cmp (
  input  logic signed [deq_pkg::KEY_W-1:0] stored_i,
  input  logic signed [deq_pkg::KEY_W-1:0] probe_i,
  output deq_pkg::cmp_res_t                res_o
);
  import deq_pkg::*;

  assign res_o.less  = (stored_i < probe_i);
  assign res_o.equal = (stored_i == probe_i);

endmodule

// File: rtl/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of signed keys in a ring store with push/pop at both ends
// and an ordered search from the front.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                             Transfer
// in_i      in   op[2:0], key[31:0]                  valid && ready
// out_o     out  ok, key_out[31:0], position[3:0],   valid && ready
//                occupancy[4:0]
//
// Pushes, refused pops, searches on an empty deque and unused codes give
// a result in the cycle after the transfer; a pop that succeeds first
// reads the ring store, then loads its result. A search walks from the
// front up to the first key not below the probe, or past all stored keys;
// each step is one read of the single store read port plus one compare.
// Input is taken only while the sequencer is idle and the result register
// is empty or draining. Reset clears pointers and count; the store itself
// is not cleared.
// ----------------------------------------------------------------------------
`include "double_ended_queue_core_defines.svh"

module double_ended_queue_core #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  deq_in_if.sink        in_i,
  deq_out_if.source     out_o
);
  import deq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [AW-1:0]       front_q, front_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic signed [KEY_W-1:0] probe_q;

  logic                    out_valid_q;
  logic                    ok_q;
  logic signed [KEY_W-1:0] key_out_q;
  logic [POS_W-1:0]        pos_q;
  logic [OCC_W-1:0]        occ_q;

  logic                    out_load;
  logic                    res_ok;
  logic signed [KEY_W-1:0] res_key;
  logic [POS_W-1:0]        res_pos;

  logic          accept;
  logic          full, empty;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] idx_nx;
  logic [AW-1:0] offset;
  logic [AW:0]   ring_sum;
  logic [AW-1:0] ring_addr;
  logic [AW-1:0] front_dec, front_inc;

  logic                    mem_we, mem_re;
  logic [AW-1:0]           mem_waddr;
  logic signed [KEY_W-1:0] rd_data;
  cmp_res_t                cmp_res;

  // handshake
  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  assign full     = (count_q == CW'(DEPTH));
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - CW'(1);
  assign idx_nx   = CW'(idx_q) + CW'(1);

  // offset from the front for the ring address adder
  always_comb begin
    offset = '0;
    if (state_q == ST_WALK) begin
      offset = idx_nx[AW-1:0];
    end else begin
      case (in_i.op)
        OP_PUSH_BACK: offset = count_q[AW-1:0];
        OP_POP_BACK:  offset = count_m1[AW-1:0];
        default:      offset = '0;
      endcase
    end
  end

  // ring address: front + offset, wrapped at DEPTH
  assign ring_sum  = {1'b0, front_q} + {1'b0, offset};
  assign ring_addr = (ring_sum >= (AW+1)'(DEPTH)) ? AW'(ring_sum - (AW+1)'(DEPTH))
                                                 : ring_sum[AW-1:0];

  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

  // sequencer
  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    count_d  = count_q;
    idx_d    = idx_q;
    out_load = 1'b0;
    res_ok   = 1'b0;
    res_key  = '0;
    res_pos  = '0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_waddr = ring_addr;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
              out_load = 1'b1;
              if (!full) begin
                mem_we  = 1'b1;
                res_ok  = 1'b1;
                count_d = count_q + CW'(1);
                if (in_i.op == OP_PUSH_FRONT) begin
                  mem_waddr = front_dec;
                  front_d   = front_dec;
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (empty) begin
                out_load = 1'b1;
              end else begin
                mem_re  = 1'b1;
                count_d = count_m1;
                state_d = ST_POP;
                if (in_i.op == OP_POP_FRONT) begin
                  front_d = front_inc;
                end
              end
            end
            OP_SEARCH: begin
              if (empty) begin
                out_load = 1'b1;
              end else begin
                mem_re  = 1'b1;
                idx_d   = '0;
                state_d = ST_WALK;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        out_load = 1'b1;
        res_ok   = 1'b1;
        res_key  = rd_data;
        state_d  = ST_IDLE;
      end
      ST_WALK: begin
        if (!cmp_res.less) begin
          // stop point: hit only on an equal key
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (cmp_res.equal) begin
            res_ok  = 1'b1;
            res_key = rd_data;
            res_pos = POS_W'(idx_q);
          end
        end else if (idx_nx == count_q) begin
          // walked past every stored key
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          mem_re = 1'b1;
          idx_d  = idx_nx[AW-1:0];
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      probe_q <= in_i.key;
    end
    if (out_load) begin
      ok_q      <= res_ok;
      key_out_q <= res_key;
      pos_q     <= res_pos;
      occ_q     <= OCC_W'(count_d);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.ok        = ok_q;
  assign out_o.key_out   = key_out_q;
  assign out_o.position  = pos_q;
  assign out_o.occupancy = occ_q;

  // ring store
  deq_ring_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_i.key),
    .re_i    (mem_re),
    .raddr_i (ring_addr),
    .rdata_o (rd_data)
  );

  // shared key compare
  deq_walk_cmp u_cmp (
    .stored_i (rd_data),
    .probe_i  (probe_q),
    .res_o    (cmp_res)
  );

  // assertions
  `DEQ_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(DEPTH), "count above depth")
  `DEQ_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_i.ready, state_q == ST_IDLE, "ready while busy")
  `DEQ_ASSERT_IMPL(a_busy_no_out, clk_i, rst_ni, state_q != ST_IDLE, !out_valid_q, "result pending while busy")
  `DEQ_ASSERT_NEXT(a_search_walk, clk_i, rst_ni, accept && in_i.op == OP_SEARCH && !empty, state_q == ST_WALK, "search did not start walk")
  `DEQ_ASSERT_NEXT(a_pop_done, clk_i, rst_ni, state_q == ST_POP, out_valid_q && ok_q, "pop result missing")

endmodule

// File: dv/double_ended_queue_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Double-ended queue core - testbench
// Drives push, pop and search operations into the deque core through its
// valid/ready channels, predicts every result with a behavioral copy of the
// ring store and compares each transfer on the result channel field by field.
// ----------------------------------------------------------------------------

import deq_pkg::*;

// Behavioral deque plus the queue of results still owed by the core
class deq_scoreboard;

  typedef struct {
    logic             ok;
    logic [KEY_W-1:0] key_out;
    logic [POS_W-1:0] position;
    logic [OCC_W-1:0] occupancy;
  } deq_result_t;

  localparam int unsigned MAX_REPORTS = 30;

  // ring store; indexes wrap at POS_W bits since the depth is 2**POS_W
  logic [KEY_W-1:0] ring [DEPTH_DEF];
  logic [POS_W-1:0] head;
  int unsigned      count;
  deq_result_t      owed_q [$];

  int unsigned errors;
  int unsigned n_checked;
  int unsigned n_ops [8];
  int unsigned n_hits;
  int unsigned n_full_refused;
  int unsigned n_empty_refused;

  function new();
    head            = '0;
    count           = 0;
    errors          = 0;
    n_checked       = 0;
    n_hits          = 0;
    n_full_refused  = 0;
    n_empty_refused = 0;
    foreach (n_ops[i]) n_ops[i] = 0;
  endfunction

  function void report(string msg);
    if (errors < MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endfunction

  function int unsigned pending();
    return owed_q.size();
  endfunction

  // stored key at offset idx from the front (idx < count)
  function logic [KEY_W-1:0] key_at(int unsigned idx);
    logic [POS_W-1:0] off;
    off = idx[POS_W-1:0];
    return ring[head + off];
  endfunction

  // apply one accepted operation and queue the result it must produce
  function void note_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
    deq_result_t      r;
    logic [POS_W-1:0] slot;
    logic [KEY_W-1:0] v;
    bit               walking;
    r.ok       = 1'b0;
    r.key_out  = '0;
    r.position = '0;
    n_ops[op]++;
    case (op)
      OP_PUSH_BACK: begin
        if (count < DEPTH_DEF) begin
          slot       = head + count[POS_W-1:0];
          ring[slot] = key;
          count++;
          r.ok = 1'b1;
        end else begin
          n_full_refused++;
        end
      end
      OP_PUSH_FRONT: begin
        if (count < DEPTH_DEF) begin
          head       = head - 1'b1;
          ring[head] = key;
          count++;
          r.ok = 1'b1;
        end else begin
          n_full_refused++;
        end
      end
      OP_POP_FRONT: begin
        if (count > 0) begin
          r.key_out = ring[head];
          head      = head + 1'b1;
          count--;
          r.ok = 1'b1;
        end else begin
          n_empty_refused++;
        end
      end
      OP_POP_BACK: begin
        if (count > 0) begin
          r.key_out = key_at(count - 1);
          count--;
          r.ok = 1'b1;
        end else begin
          n_empty_refused++;
        end
      end
      OP_SEARCH: begin
        // walk from the front while the stored key is below the probe
        walking = 1'b1;
        for (int unsigned i = 0; i < count && walking; i++) begin
          v = key_at(i);
          if ($signed(v) >= $signed(key)) begin
            walking = 1'b0;
            if (v == key) begin
              r.ok       = 1'b1;
              r.key_out  = v;
              r.position = i[POS_W-1:0];
              n_hits++;
            end
          end
        end
      end
      default: ;  // unused codes leave the deque alone
    endcase
    r.occupancy = count[OCC_W-1:0];
    owed_q.push_back(r);
  endfunction

  function void check_result(logic ok, logic [KEY_W-1:0] key_out,
                             logic [POS_W-1:0] position, logic [OCC_W-1:0] occupancy);
    deq_result_t e;
    if (owed_q.size() == 0) begin
      report("result transfer with no operation outstanding");
      return;
    end
    e = owed_q.pop_front();
    n_checked++;
    if (ok !== e.ok)
      report($sformatf("result %0d ok %b, expected %b", n_checked, ok, e.ok));
    if (key_out !== e.key_out)
      report($sformatf("result %0d key_out %h, expected %h", n_checked, key_out, e.key_out));
    if (position !== e.position)
      report($sformatf("result %0d position %0d, expected %0d", n_checked, position,
                       e.position));
    if (occupancy !== e.occupancy)
      report($sformatf("result %0d occupancy %0d, expected %0d", n_checked, occupancy,
                       e.occupancy));
  endfunction

endclass

module double_ended_queue_core_tb;

  localparam logic [OP_W-1:0]  OP_RSVD_FIRST  = 3'd5;
  localparam logic [OP_W-1:0]  OP_RSVD_LAST   = 3'd7;
  localparam logic [KEY_W-1:0] KEY_MIN        = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX        = 32'h7FFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_STEP       = 32'h1000_0000;
  localparam int unsigned      N_RANDOM       = 1520;
  localparam int unsigned      N_CALM         = 200;
  localparam int unsigned      HOLD_AT        = 400;
  localparam int unsigned      HOLD_ITEMS     = 60;
  localparam int unsigned      RX_HOLD_CYCLES = 120;
  localparam int unsigned      PAUSE_AT       = 800;
  localparam int unsigned      DRAIN_CYCLES   = 2 * DEPTH_DEF + 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  deq_in_if  in_if ();
  deq_out_if out_if ();

  deq_scoreboard sb = new();

  bit tx_stalls_on = 1'b0;
  bit rx_stalls_on = 1'b0;
  bit rx_hold_req  = 1'b0;

  double_ended_queue_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.ok, out_if.key_out, out_if.position, out_if.occupancy);
  end

  // result side back-pressure: random short stalls plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left  = 0;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 99) < 12) begin
        stall_left = $urandom_range(0, 4);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // offer one operation and hold it until the transfer
  task automatic send_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
    in_if.valid <= 1'b1;
    in_if.op    <= op;
    in_if.key   <= key;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_op(op, key);
  endtask

  task automatic idle_cycles(int unsigned n);
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // stop offering and wait until every owed result has been transferred
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // key at or above base, mostly a small step, sometimes a big jump
  function automatic logic [KEY_W-1:0] key_above(logic [KEY_W-1:0] base);
    longint t;
    t = longint'($signed(base));
    if ($urandom_range(0, 9) == 0) t += longint'($urandom_range(0, 32'h0100_0000));
    else                           t += longint'($urandom_range(0, 3));
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    return t[KEY_W-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] key_below(logic [KEY_W-1:0] base);
    longint t;
    t = longint'($signed(base));
    if ($urandom_range(0, 9) == 0) t -= longint'($urandom_range(0, 32'h0100_0000));
    else                           t -= longint'($urandom_range(0, 3));
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[KEY_W-1:0];
  endfunction

  // one random operation; mostly keeps the deque sorted so that searches hit
  task automatic pick_op(int unsigned grow_pct, output logic [OP_W-1:0] op,
                         output logic [KEY_W-1:0] key);
    int unsigned sel;
    int unsigned cnt;
    bit          tidy;
    bit          at_back;
    cnt     = sb.count;
    tidy    = ($urandom_range(0, 99) < 85);
    at_back = ($urandom_range(0, 1) == 1);
    sel     = $urandom_range(0, 99);
    key     = $urandom();
    if (sel < 2) begin
      op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    end else if (sel < 30) begin
      op  = OP_SEARCH;
      sel = $urandom_range(0, 99);
      if (cnt > 0 && sel < 50)      key = sb.key_at($urandom_range(0, cnt - 1));
      else if (cnt > 0 && sel < 75) key = sb.key_at($urandom_range(0, cnt - 1)) +
                                          ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
      else if (sel < 85)            key = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
    end else if ($urandom_range(0, 99) < grow_pct) begin
      op = at_back ? OP_PUSH_BACK : OP_PUSH_FRONT;
      if (tidy) begin
        if ($urandom_range(0, 19) == 0)
          key = at_back ? KEY_MAX : KEY_MIN;
        else if (cnt == 0)
          key = $urandom_range(0, 64) - 32;
        else if (at_back)
          key = key_above(sb.key_at(cnt - 1));
        else
          key = key_below(sb.key_at(0));
      end
    end else begin
      op = at_back ? OP_POP_BACK : OP_POP_FRONT;
    end
  endtask

  initial begin
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    int unsigned      grow_pct;
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.op    <= OP_PUSH_BACK;
    in_if.key   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty deque: refused pops, search on nothing, unused codes
    send_op(OP_POP_FRONT, 32'h5A5A_A5A5);
    send_op(OP_POP_BACK, 32'hA5A5_5A5A);
    send_op(OP_SEARCH, '0);
    for (int c = int'(OP_RSVD_FIRST); c <= int'(OP_RSVD_LAST); c++)
      send_op(c[OP_W-1:0], $urandom());
    // fill to the brim in ascending order from both ends; front wraps the ring
    for (int j = 8; j < 16; j++) send_op(OP_PUSH_BACK, KEY_MIN + KEY_STEP * j);
    for (int j = 7; j >= 0; j--) send_op(OP_PUSH_FRONT, KEY_MIN + KEY_STEP * j);
    send_op(OP_PUSH_BACK, KEY_MAX);                  // refused, deque full
    send_op(OP_SEARCH, KEY_MIN);                     // hit at the front
    send_op(OP_SEARCH, KEY_MIN + KEY_STEP * 15);     // hit at the last position
    send_op(OP_SEARCH, KEY_MAX);                     // walks past every key
    send_op(OP_SEARCH, KEY_MIN + KEY_STEP * 3 + 1);  // stops on a larger key
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '1);
    drain_results();

    // random traffic in grow / shrink / balanced phases
    tx_stalls_on = 1'b1;
    rx_stalls_on = 1'b1;
    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_CALM) begin
        tx_stalls_on = 1'b0;
        rx_stalls_on = 1'b0;
      end
      if (n == HOLD_AT) rx_hold_req = 1'b1;
      if (n == PAUSE_AT) drain_results();
      case ((n / 120) % 3)
        0:       grow_pct = 75;
        1:       grow_pct = 25;
        default: grow_pct = 50;
      endcase
      // back-to-back offers while the result side is held off
      if (tx_stalls_on && !(n >= HOLD_AT && n < HOLD_AT + HOLD_ITEMS) &&
          $urandom_range(0, 99) < 15)
        idle_cycles($urandom_range(1, 5));
      pick_op(grow_pct, op, key);
      send_op(op, key);
    end
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d results: %0d push back, %0d push front, %0d pop front, %0d pop back,",
             sb.n_checked, sb.n_ops[OP_PUSH_BACK], sb.n_ops[OP_PUSH_FRONT],
             sb.n_ops[OP_POP_FRONT], sb.n_ops[OP_POP_BACK]);
    $display("%0d searches (%0d hits), %0d pushes on full, %0d pops on empty, %0d unused codes",
             sb.n_ops[OP_SEARCH], sb.n_hits, sb.n_full_refused, sb.n_empty_refused,
             sb.n_ops[5] + sb.n_ops[6] + sb.n_ops[7]);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_in_if.sv
rtl/deq_out_if.sv
rtl/deq_ring_mem.sv
rtl/deq_walk_cmp.sv
rtl/double_ended_queue_core.sv
dv/double_ended_queue_core_tb.sv
